FILE: sv/imc_pkg.sv
// Shared types and constants for the injective mapping check unit.
// Holds verdict codes, configuration register indexes and storage sizes.
// Used by the top module of the block and by its checker.
package imc_pkg;

  // Default number of target slots in the seen-flag store.
  localparam int unsigned MAX_TARGETS_DEF = 1024;

  // Fixed field widths of the external interface.
  localparam int unsigned IDX_IN_W = 17;
  localparam int unsigned TC_W     = 11;
  localparam int unsigned CNT_OUT_W = 11;

  // Reset value of the target count register.
  localparam logic [TC_W-1:0] TC_RESET = 11'd1024;

  // Width of the list tag stored in each seen-flag entry. Tag zero means never seen.
  localparam int unsigned EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 8'hFF;
  localparam logic [EPOCH_W-1:0] EPOCH_CLEAR = 8'd0;

  // Verdict codes reported with each closed list.
  typedef enum logic [1:0] {
    VERDICT_OK    = 2'd0,
    VERDICT_RANGE = 2'd1,
    VERDICT_DUP   = 2'd2,
    VERDICT_COUNT = 2'd3
  } verdict_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_TARGET_COUNT = 1'b0,
    CFG_FULL_PERM    = 1'b1
  } cfg_reg_t;

endpackage

FILE: sv/imc_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Parameterized by data width and depth; no package dependency.
module imc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/injective_mapping_check_unit.sv
// Injective mapping check: one target index per request, one verdict per list.
// out_valid rises once a closing request has passed the second stage and loaded the result register.
// Throughput: one request per cycle through the seen-store read/modify/write loop;
// in_ready also drops while a closing request waits behind a held result.
// Every 255 lists, and once after reset, a sweep over all MAX_TARGETS entries clears the
// seen store; in_ready is low from that list's close to the sweep's end. Sync reset.
module injective_mapping_check_unit #(
  parameter int unsigned MAX_TARGETS = imc_pkg::MAX_TARGETS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [imc_pkg::IDX_IN_W-1:0] in_target_index,
  input  logic                               in_last_element,
  input  logic                               in_empty_list,
  // Result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_verdict,
  output logic [imc_pkg::CNT_OUT_W-1:0]      out_element_count,
  // Configuration channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [0:0]                         cfg_index,
  input  logic [imc_pkg::TC_W-1:0]           cfg_data
);

  localparam int unsigned IDX_W  = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_TARGETS + 2);
  localparam int unsigned CMP_W  = imc_pkg::IDX_IN_W;
  localparam int unsigned CEXT_W = CNT_W + imc_pkg::CNT_OUT_W;
  localparam logic [CMP_W-1:0] MAX_CMP   = CMP_W'(MAX_TARGETS);
  localparam logic [CNT_W-1:0] CNT_SAT   = CNT_W'(MAX_TARGETS + 1);
  localparam logic [IDX_W-1:0] CLR_LAST  = IDX_W'(MAX_TARGETS - 1);

  // Configuration registers
  logic [imc_pkg::TC_W-1:0] tc_r, tc_nxt;
  logic                     mode_r, mode_nxt;

  // Clearing sweep and list tag
  logic                        clr_busy_r, clr_busy_nxt;
  logic [IDX_W-1:0]            clr_addr_r, clr_addr_nxt;
  logic [imc_pkg::EPOCH_W-1:0] epoch_r, epoch_nxt;

  // Second stage: request waiting for its seen-store read data
  logic             s1_vld_r, s1_vld_nxt;
  logic             s1_last_r;
  logic             s1_empty_r;
  logic             s1_oor_r;
  logic [IDX_W-1:0] s1_idx_r;

  // Forwarding of the most recent write-back
  logic             fwd_vld_r, fwd_vld_nxt;
  logic [IDX_W-1:0] fwd_idx_r, fwd_idx_nxt;

  // Per-list gathered state
  imc_pkg::verdict_t fail_r, fail_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  // Result register
  logic                          out_valid_r, out_valid_nxt;
  imc_pkg::verdict_t             out_verdict_r;
  logic [imc_pkg::CNT_OUT_W-1:0] out_cnt_r;

  // Internal combinational signals
  logic                        in_accept;
  logic                        s1_fire;
  logic [CMP_W-1:0]            tc_ext;
  logic [CMP_W-1:0]            eff_limit;
  logic                        in_oor;
  logic                        ram_we;
  logic [IDX_W-1:0]            ram_waddr;
  logic [imc_pkg::EPOCH_W-1:0] ram_wdata;
  logic [imc_pkg::EPOCH_W-1:0] ram_rdata;
  logic                        seen;
  logic                        s1_wr;
  imc_pkg::verdict_t           code;
  imc_pkg::verdict_t           fail_new;
  logic [CNT_W-1:0]            cnt_new;
  logic                        count_bad;
  imc_pkg::verdict_t           verdict_new;
  logic [CEXT_W-1:0]           cnt_ext;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_comb begin
    tc_nxt   = tc_r;
    mode_nxt = mode_r;
    if (cfg_valid) begin
      case (imc_pkg::cfg_reg_t'(cfg_index))
        imc_pkg::CFG_TARGET_COUNT: tc_nxt   = cfg_data;
        imc_pkg::CFG_FULL_PERM:    mode_nxt = cfg_data[0];
        default: begin
          tc_nxt   = tc_r;
          mode_nxt = mode_r;
        end
      endcase
    end
  end

  // Effective limit: target count clipped to the store depth.
  assign tc_ext    = CMP_W'(tc_r);
  assign eff_limit = (tc_ext > MAX_CMP) ? MAX_CMP : tc_ext;
  assign in_oor    = in_target_index[CMP_W-1] ||
                     ({1'b0, in_target_index[CMP_W-2:0]} >= eff_limit);

  // The second stage advances unless it closes a list while the result register is held.
  assign s1_fire = s1_vld_r && (!s1_last_r || !out_valid_r || out_ready);

  // No request during a sweep, nor behind a list close that starts one.
  assign in_ready = !clr_busy_r && (!s1_vld_r || s1_fire) &&
                    !(s1_vld_r && s1_last_r && (epoch_r == imc_pkg::EPOCH_LAST));
  assign in_accept = in_valid && in_ready;

  // Seen store: each entry holds the tag of the list that last marked it.
  imc_ram #(
    .WIDTH (imc_pkg::EPOCH_W),
    .DEPTH (MAX_TARGETS)
  ) u_seen_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_accept && !in_empty_list),
    .raddr (in_target_index[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // Element check with forwarding of the write made while this read was issued.
  always_comb begin
    seen  = (ram_rdata == epoch_r) || (fwd_vld_r && (fwd_idx_r == s1_idx_r));
    s1_wr = s1_fire && !s1_empty_r && !s1_oor_r;
    if (s1_empty_r) begin
      code = imc_pkg::VERDICT_OK;
    end else if (s1_oor_r) begin
      code = imc_pkg::VERDICT_RANGE;
    end else if (seen) begin
      code = imc_pkg::VERDICT_DUP;
    end else begin
      code = imc_pkg::VERDICT_OK;
    end
  end

  // Write port is shared between the sweep and element write-back.
  always_comb begin
    if (clr_busy_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = imc_pkg::EPOCH_CLEAR;
    end else begin
      ram_we    = s1_wr;
      ram_waddr = s1_idx_r;
      ram_wdata = epoch_r;
    end
  end

  // Running failure, count and the verdict of a closing request.
  always_comb begin
    fail_new = (fail_r == imc_pkg::VERDICT_OK) ? code : fail_r;
    cnt_new  = cnt_r;
    if (!s1_empty_r && (cnt_r < CNT_SAT)) begin
      cnt_new = cnt_r + CNT_W'(1);
    end
    count_bad   = mode_r && ((tc_ext > MAX_CMP) || (CMP_W'(cnt_new) != eff_limit));
    verdict_new = count_bad ? imc_pkg::VERDICT_COUNT : fail_new;
    cnt_ext     = CEXT_W'(cnt_new);
  end

  // Next state of the pipeline, list state, tags and sweep.
  always_comb begin
    s1_vld_nxt    = in_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_vld_r);
    fwd_vld_nxt   = fwd_vld_r;
    fwd_idx_nxt   = fwd_idx_r;
    fail_nxt      = fail_r;
    cnt_nxt       = cnt_r;
    epoch_nxt     = epoch_r;
    clr_busy_nxt  = clr_busy_r;
    clr_addr_nxt  = clr_addr_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (s1_fire) begin
      if (s1_last_r) begin
        fail_nxt      = imc_pkg::VERDICT_OK;
        cnt_nxt       = '0;
        fwd_vld_nxt   = 1'b0;
        out_valid_nxt = 1'b1;
        if (epoch_r == imc_pkg::EPOCH_LAST) begin
          epoch_nxt    = imc_pkg::EPOCH_FIRST;
          clr_busy_nxt = 1'b1;
          clr_addr_nxt = '0;
        end else begin
          epoch_nxt = epoch_r + imc_pkg::EPOCH_W'(1);
        end
      end else begin
        fail_nxt = fail_new;
        cnt_nxt  = cnt_new;
        if (s1_wr) begin
          fwd_vld_nxt = 1'b1;
          fwd_idx_nxt = s1_idx_r;
        end
      end
    end

    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + IDX_W'(1);
      if (clr_addr_r == CLR_LAST) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r        <= imc_pkg::TC_RESET;
      mode_r      <= 1'b0;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      epoch_r     <= imc_pkg::EPOCH_FIRST;
      s1_vld_r    <= 1'b0;
      fwd_vld_r   <= 1'b0;
      fail_r      <= imc_pkg::VERDICT_OK;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tc_r        <= tc_nxt;
      mode_r      <= mode_nxt;
      clr_busy_r  <= clr_busy_nxt;
      clr_addr_r  <= clr_addr_nxt;
      epoch_r     <= epoch_nxt;
      s1_vld_r    <= s1_vld_nxt;
      fwd_vld_r   <= fwd_vld_nxt;
      fail_r      <= fail_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    fwd_idx_r <= fwd_idx_nxt;
    if (in_accept) begin
      s1_last_r  <= in_last_element;
      s1_empty_r <= in_empty_list;
      s1_oor_r   <= in_oor;
      s1_idx_r   <= in_target_index[IDX_W-1:0];
    end
    if (s1_fire && s1_last_r) begin
      out_verdict_r <= verdict_new;
      out_cnt_r     <= cnt_ext[imc_pkg::CNT_OUT_W-1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_verdict       = out_verdict_r;
  assign out_element_count = out_cnt_r;

endmodule

FILE: sv/imc_checker.sv
// Port-level checker for the injective mapping check unit, bound to the top level.
// Depends on imc_pkg for verdict codes and register indexes.
module imc_checker #(
  parameter int unsigned MAX_TARGETS = imc_pkg::MAX_TARGETS_DEF
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               in_last_element,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [1:0]                         out_verdict,
  input logic [imc_pkg::CNT_OUT_W-1:0]      out_element_count,
  input logic                               cfg_valid,
  input logic                               cfg_ready,
  input logic [0:0]                         cfg_index,
  input logic [imc_pkg::TC_W-1:0]           cfg_data
);

  localparam int unsigned CMP_W = imc_pkg::IDX_IN_W;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_TARGETS);

  // Shadow copies of the configuration registers, seen from the port.
  logic [imc_pkg::TC_W-1:0] tc_r;
  logic                     mode_r;
  logic [CMP_W-1:0]         eff_limit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r   <= imc_pkg::TC_RESET;
      mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == imc_pkg::CFG_TARGET_COUNT) begin
        tc_r <= cfg_data;
      end else begin
        mode_r <= cfg_data[0];
      end
    end
  end

  assign eff_limit = (CMP_W'(tc_r) > MAX_CMP) ? MAX_CMP : CMP_W'(tc_r);

  // A held result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_verdict) &&
                                $stable(out_element_count))
    else $error("result changed while stalled");

  // A closing request loads the result register at the next edge when the sink drains.
  a_close_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last_element) ##1 out_ready |=> out_valid)
    else $error("closing request produced no result");

  // A valid verdict in full-permutation mode means the list covered every target.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mode_r && (out_verdict == imc_pkg::VERDICT_OK) |->
      (out_element_count == eff_limit[imc_pkg::CNT_OUT_W-1:0]))
    else $error("full permutation passed with wrong count");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind injective_mapping_check_unit imc_checker #(.MAX_TARGETS(MAX_TARGETS)) u_imc_checker (.*);
